>>> design/elf_pkg.sv
// Package for the escaped length framer: beat types, frame byte codes,
// controller state and command/status structs. No dependencies.
package elf_pkg;

    localparam int MAX_BYTES_DEFAULT = 16;
    localparam int FILL_W = 5;
    localparam int SLEN_W = 6;

    localparam logic [7:0] SOF_BYTE = 8'h7E;
    localparam logic [7:0] EOF_BYTE = 8'h7F;
    localparam logic [7:0] ESC_BYTE = 8'h7D;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       first_of_frame;
        logic       last_of_frame;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_done;
        logic       overflow;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SOF,
        ST_LEN,
        ST_FETCH,
        ST_LOAD,
        ST_ESC,
        ST_DATA,
        ST_EOF
    } state_t;

    typedef enum logic [2:0] {
        SEL_SOF,
        SEL_LEN,
        SEL_ESC,
        SEL_DATA,
        SEL_EOF
    } emit_sel_t;

    typedef struct packed {
        logic      store;
        logic      rd;
        logic      load;
        logic      emit;
        emit_sel_t sel;
        logic      clear;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic idx_done;
        logic rd_esc;
    } dp_status_t;

    function automatic logic needs_escape(input logic [7:0] b);
        return (b == SOF_BYTE) || (b == EOF_BYTE) || (b == ESC_BYTE);
    endfunction

endpackage

>>> design/elf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module elf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/elf_ctrl.sv
// Controller state machine of the escaped length framer.
// Depends on elf_pkg; drives commands to elf_dp and reads its status.
module elf_ctrl
    import elf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_last,
    output logic       s_ready,
    input  dp_status_t sts,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_last) state_next = ST_SOF;
            end
            ST_SOF: begin
                if (sts.out_free) state_next = ST_LEN;
            end
            ST_LEN: begin
                if (sts.out_free) state_next = sts.idx_done ? ST_EOF : ST_FETCH;
            end
            ST_FETCH: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                state_next = sts.rd_esc ? ST_ESC : ST_DATA;
            end
            ST_ESC: begin
                if (sts.out_free) state_next = ST_DATA;
            end
            ST_DATA: begin
                if (sts.out_free) state_next = sts.idx_done ? ST_EOF : ST_FETCH;
            end
            ST_EOF: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        cmd.sel = SEL_SOF;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.store = s_valid;
            end
            ST_SOF: begin
                cmd.emit = sts.out_free;
                cmd.sel  = SEL_SOF;
            end
            ST_LEN: begin
                cmd.emit = sts.out_free;
                cmd.sel  = SEL_LEN;
            end
            ST_FETCH: begin
                cmd.rd = 1'b1;
            end
            ST_LOAD: begin
                cmd.load = 1'b1;
            end
            ST_ESC: begin
                cmd.emit = sts.out_free;
                cmd.sel  = SEL_ESC;
            end
            ST_DATA: begin
                cmd.emit = sts.out_free;
                cmd.sel  = SEL_DATA;
            end
            ST_EOF: begin
                cmd.emit  = sts.out_free;
                cmd.sel   = SEL_EOF;
                cmd.clear = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store |-> state_reg == ST_IDLE)
        else $error("store outside idle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free)
        else $error("emit while output register is held");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FETCH) |=> state_reg == ST_LOAD)
        else $error("fetch not followed by load");

endmodule

>>> design/elf_dp.sv
// Datapath of the escaped length framer: counters, message store,
// byte select and output register. Depends on elf_pkg and elf_ram.
module elf_dp
    import elf_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  in_beat_t   s_data,
    input  ctrl_cmd_t  cmd,
    output dp_status_t sts,
    output logic       m_valid,
    input  logic       m_ready,
    output out_beat_t  m_data
);

    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_BYTES);

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [SLEN_W-1:0] slen_reg, slen_next;
    logic              drop_reg, drop_next;
    logic [FILL_W-1:0] idx_reg, idx_next;
    logic [7:0]        byte_reg;
    logic              m_valid_reg, m_valid_next;
    out_beat_t         m_data_reg, m_data_next;

    logic [FILL_W-1:0] fill_base;
    logic [SLEN_W-1:0] slen_base;
    logic              drop_base;
    logic              wr_en;
    logic [7:0]        rd_data;
    logic              out_free;
    logic [7:0]        emit_byte;

    elf_ram #(
        .WIDTH(8),
        .DEPTH(MAX_BYTES)
    ) u_store (
        .aclk (aclk),
        .we   (wr_en),
        .waddr(fill_base[AW-1:0]),
        .wdata(s_data.byte_value),
        .re   (cmd.rd),
        .raddr(idx_reg[AW-1:0]),
        .rdata(rd_data)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        fill_base = s_data.first_of_frame ? '0 : fill_reg;
        slen_base = s_data.first_of_frame ? '0 : slen_reg;
        drop_base = s_data.first_of_frame ? 1'b0 : drop_reg;
        wr_en     = cmd.store && (fill_base < FILL_MAX);
        fill_next = fill_reg;
        slen_next = slen_reg;
        drop_next = drop_reg;
        idx_next  = idx_reg;
        if (cmd.store) begin
            idx_next = '0;
            if (fill_base < FILL_MAX) begin
                fill_next = fill_base + FILL_W'(1);
                slen_next = slen_base
                    + (needs_escape(s_data.byte_value) ? SLEN_W'(2) : SLEN_W'(1));
                drop_next = drop_base;
            end else begin
                fill_next = fill_base;
                slen_next = slen_base;
                drop_next = 1'b1;
            end
        end
        if (cmd.load) begin
            idx_next = idx_reg + FILL_W'(1);
        end
        if (cmd.clear) begin
            fill_next = '0;
            slen_next = '0;
            drop_next = 1'b0;
            idx_next  = '0;
        end
    end

    always_comb begin
        unique case (cmd.sel)
            SEL_SOF:  emit_byte = SOF_BYTE;
            SEL_LEN:  emit_byte = 8'(slen_reg) + 8'd1;
            SEL_ESC:  emit_byte = ESC_BYTE;
            SEL_DATA: emit_byte = byte_reg;
            SEL_EOF:  emit_byte = EOF_BYTE;
            default:  emit_byte = EOF_BYTE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (cmd.emit) begin
            m_valid_next           = 1'b1;
            m_data_next.out_byte   = emit_byte;
            m_data_next.frame_done = (cmd.sel == SEL_EOF);
            m_data_next.overflow   = drop_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            slen_reg    <= '0;
            drop_reg    <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            slen_reg    <= slen_next;
            drop_reg    <= drop_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (cmd.load) begin
            byte_reg <= rd_data;
        end
    end

    assign sts.out_free = out_free;
    assign sts.idx_done = (idx_reg == fill_reg);
    assign sts.rd_esc   = needs_escape(rd_data);
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_MAX && idx_reg <= fill_reg)
        else $error("fill count or read index out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        SLEN_W'(fill_reg) <= slen_reg
        && {1'b0, slen_reg} <= {1'b0, fill_reg, 1'b0})
        else $error("stuffed length disagrees with fill count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.frame_done |-> m_data_reg.out_byte == EOF_BYTE)
        else $error("frame done on a byte other than the end byte");

endmodule

>>> design/escaped_length_framer.sv
// Escaped length framer, top level: byte-stuffing framer with a length byte.
// Depends on elf_pkg, elf_ctrl, elf_dp (and elf_ram inside elf_dp).
//
// Input channel s_*: one message byte per beat (type byte first, marked by
// first_of_frame; the final byte marked by last_of_frame). Bytes without
// last_of_frame are taken one per cycle while idle. Up to MAX_BYTES bytes are
// stored; later bytes are dropped and flag the frame as overflow.
// Output channel m_*: on the final byte the frame is sent one byte per beat:
// 0x7E, length (stuffed bytes plus end byte), stored bytes with 0x7D in front
// of any 0x7E/0x7F/0x7D, then 0x7F with frame_done set.
// The start byte follows the final input beat via the ST_SOF state and the
// output register. Each stored byte takes a store read, a load, an escape
// byte if it needs one, and its send, paced by the single read port of the
// message store. s_ready is low while a frame is being sent.
// Reset (aresetn low, synchronous) clears counters, flags and m_valid; the
// output data and the message store are not cleared and need no clearing.
// A stall on m_ready holds the current beat and pauses the frame sequence.
module escaped_length_framer
    import elf_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    elf_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_last (s_data.last_of_frame),
        .s_ready(s_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    elf_dp #(
        .MAX_BYTES(MAX_BYTES)
    ) u_dp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_data (s_data),
        .cmd    (cmd),
        .sts    (sts),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

endmodule

>>> tb/frame_checker.sv
// Scoreboard for the escaped length framer: rebuilds each stuffed frame from
// the accepted input beats and compares every output beat against it.
// Depends on elf_pkg for the beat types and the frame byte codes.
module frame_checker
    import elf_pkg::*;
#(
    parameter int CAPACITY = MAX_BYTES_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_beat_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_beat_t m_data,
    output int        mismatches,
    output int        pending,
    output int        frames_seen,
    output int        beats_seen
);

    localparam int CAP_AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [7:0]        held_bytes [CAPACITY];
    logic [FILL_W-1:0] held_count;
    logic [SLEN_W-1:0] stuffed_count;
    logic              lost_bytes;
    out_beat_t         frame_bytes_due [$];

    initial begin
        mismatches = 0;
        pending = 0;
        frames_seen = 0;
        beats_seen = 0;
        held_count = '0;
        stuffed_count = '0;
        lost_bytes = 1'b0;
    end

    function automatic logic is_reserved_code(input logic [7:0] v);
        return (v == SOF_BYTE) || (v == EOF_BYTE) || (v == ESC_BYTE);
    endfunction

    function automatic out_beat_t make_beat(input logic [7:0] v, input logic done,
                                            input logic ovf);
        out_beat_t r;
        r.out_byte = v;
        r.frame_done = done;
        r.overflow = ovf;
        return r;
    endfunction

    task automatic absorb_beat(input in_beat_t b);
        logic [7:0] len_code;
        int i;
        if (b.first_of_frame) begin
            held_count = '0;
            stuffed_count = '0;
            lost_bytes = 1'b0;
        end
        if (held_count < CAPACITY) begin
            held_bytes[held_count[CAP_AW-1:0]] = b.byte_value;
            held_count = held_count + 1'b1;
            stuffed_count = stuffed_count
                + (is_reserved_code(b.byte_value) ? SLEN_W'(2) : SLEN_W'(1));
        end else begin
            lost_bytes = 1'b1;
        end
        if (!b.last_of_frame)
            return;
        len_code = 8'(stuffed_count) + 8'd1;
        frame_bytes_due.push_back(make_beat(SOF_BYTE, 1'b0, lost_bytes));
        frame_bytes_due.push_back(make_beat(len_code, 1'b0, lost_bytes));
        for (i = 0; i < held_count; i++) begin
            if (is_reserved_code(held_bytes[i]))
                frame_bytes_due.push_back(make_beat(ESC_BYTE, 1'b0, lost_bytes));
            frame_bytes_due.push_back(make_beat(held_bytes[i], 1'b0, lost_bytes));
        end
        frame_bytes_due.push_back(make_beat(EOF_BYTE, 1'b1, lost_bytes));
        held_count = '0;
        stuffed_count = '0;
        lost_bytes = 1'b0;
    endtask

    task automatic check_beat(input out_beat_t got);
        out_beat_t want;
        beats_seen++;
        if (frame_bytes_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected output beat: byte %h done %b overflow %b",
                         got.out_byte, got.frame_done, got.overflow);
            return;
        end
        want = frame_bytes_due.pop_front();
        if (want.frame_done)
            frames_seen++;
        if (got.out_byte !== want.out_byte || got.frame_done !== want.frame_done ||
            got.overflow !== want.overflow) begin
            mismatches++;
            if (mismatches <= 10)
                $display("output beat %0d: expected byte %h done %b overflow %b, got %h %b %b",
                         beats_seen, want.out_byte, want.frame_done, want.overflow,
                         got.out_byte, got.frame_done, got.overflow);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            held_count = '0;
            stuffed_count = '0;
            lost_bytes = 1'b0;
            frame_bytes_due.delete();
        end else begin
            if (s_valid && s_ready)
                absorb_beat(s_data);
            if (m_valid && m_ready)
                check_beat(m_data);
        end
        pending = frame_bytes_due.size();
    end

endmodule

>>> tb/testbench.sv
// Top of the escaped length framer regression: clock, reset, message stimulus,
// output backpressure and the verdict. Depends on elf_pkg, the framer RTL and
// frame_checker.
module testbench;
    import elf_pkg::*;

    localparam int CAPACITY = MAX_BYTES_DEFAULT;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_ITEMS = 200;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    int mismatches;
    int pending;
    int frames_seen;
    int beats_seen;
    int cycle_count = 0;
    int items_sent = 0;
    int messages_sent = 0;
    int overflow_messages = 0;
    int ready_run = 0;

    always #2 aclk = ~aclk;

    escaped_length_framer #(
        .MAX_BYTES(CAPACITY)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    frame_checker #(
        .CAPACITY(CAPACITY)
    ) scoreboard (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .mismatches(mismatches),
        .pending(pending),
        .frames_seen(frames_seen),
        .beats_seen(beats_seen)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still due", cycle_count, pending);
            $display("escaped_length_framer regression: fail");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_payload_byte();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return SOF_BYTE;
        if (r < 16)
            return EOF_BYTE;
        if (r < 24)
            return ESC_BYTE;
        if (r < 28)
            return 8'h00;
        if (r < 32)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return $urandom_range(1, 6);
        if (r < 85)
            return $urandom_range(7, CAPACITY);
        return $urandom_range(CAPACITY + 1, CAPACITY + 4);
    endfunction

    // ready runs and stalls of random length, with occasional long stall-free stretches
    always @(negedge aclk) begin
        if (ready_run > 0) begin
            ready_run--;
        end else if (m_ready) begin
            ready_run = pick_gap();
            if (ready_run > 0)
                m_ready <= 1'b0;
            else
                ready_run = ($urandom_range(9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 12);
        end else begin
            m_ready <= 1'b1;
            ready_run = ($urandom_range(9) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 12);
        end
    end

    task automatic send_beat(input logic [7:0] v, input logic sof, input logic eof,
                             input bit no_gap);
        int gap;
        in_beat_t b;
        b.byte_value = v;
        b.first_of_frame = sof;
        b.last_of_frame = eof;
        gap = no_gap ? 0 : pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_message(input int len, input bit marked, input bit no_gap);
        int i;
        messages_sent++;
        if (len > CAPACITY)
            overflow_messages++;
        for (i = 0; i < len; i++)
            send_beat(pick_payload_byte(), marked && (i == 0), i == len - 1, no_gap);
    endtask

    task automatic hold_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    initial begin
        int directed_items;
        int r;
        int i;
        bit no_gap;
        bit drained_mid;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        send_beat(8'h00, 1'b1, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b1, 1'b0);
        send_beat(SOF_BYTE, 1'b1, 1'b0, 1'b0);
        send_beat(EOF_BYTE, 1'b0, 1'b0, 1'b0);
        send_beat(ESC_BYTE, 1'b0, 1'b1, 1'b0);
        send_beat(8'h41, 1'b0, 1'b0, 1'b0);
        send_beat(ESC_BYTE, 1'b0, 1'b1, 1'b0);
        send_beat(8'h11, 1'b1, 1'b0, 1'b0);
        send_beat(8'h22, 1'b0, 1'b0, 1'b0);
        send_beat(8'h33, 1'b1, 1'b0, 1'b0);
        send_beat(SOF_BYTE, 1'b0, 1'b1, 1'b0);
        for (i = 0; i < CAPACITY; i++)
            send_beat(ESC_BYTE, i == 0, 1'b0, 1'b1);
        send_beat(8'h55, 1'b0, 1'b1, 1'b0);
        messages_sent += 7;
        overflow_messages++;
        directed_items = items_sent;

        hold_until_drained();

        drained_mid = 1'b0;
        while (items_sent < directed_items + RANDOM_ITEMS) begin
            r = $urandom_range(99);
            no_gap = ($urandom_range(4) == 0);
            if (r < 70)
                send_message(pick_length(), 1'b1, no_gap);
            else if (r < 82)
                send_message(pick_length(), 1'b0, no_gap);
            else
                send_beat(pick_payload_byte(), 1'($urandom_range(1)),
                          $urandom_range(3) == 0, no_gap);
            if (!drained_mid && items_sent >= directed_items + RANDOM_ITEMS / 2) begin
                hold_until_drained();
                drained_mid = 1'b1;
            end
        end
        send_beat(pick_payload_byte(), 1'b0, 1'b1, 1'b0);

        hold_until_drained();
        repeat (64) @(posedge aclk);

        $display("sent %0d input beats in %0d messages, %0d of them past capacity",
                 items_sent, messages_sent, overflow_messages);
        $display("checked %0d output beats across %0d frames, %0d mismatches",
                 beats_seen, frames_seen, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("escaped_length_framer regression: pass");
        else
            $display("escaped_length_framer regression: fail");
        $finish;
    end

endmodule

>>> sim.f
design/elf_pkg.sv
design/elf_ram.sv
design/elf_ctrl.sv
design/elf_dp.sv
design/escaped_length_framer.sv
tb/frame_checker.sv
tb/testbench.sv
